>>> rtl/m52_pkg.sv
// shared types and constants of the matern 5/2 kernel evaluator
`timescale 1ns / 1ps
package m52_pkg;

    localparam int          ACC_W   = 38;
    localparam logic [37:0] ACC_MAX = {38{1'b1}};
    localparam logic [63:0] C5_Q32  = 64'd9603838835;
    localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
    localparam logic [63:0] LIM_A   = 64'h0000_0020_0000_0000;
    localparam logic [4:0]  N_TERMS = 5'd20;
    localparam logic [2:0]  N_SQUARES_LAST = 3'd4;
    // (2^63 + 1) / 3, exact floor division by three for dividends below 2^63
    localparam logic [63:0] RECIP3_Q63 = 64'h2AAA_AAAA_AAAA_AAAB;

    // one closed point pair
    typedef struct packed {
        logic [ACC_W-1:0] sq_dist;
        logic             sat;
    } m52_item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] x;
        logic [63:0] y;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [4:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/m52_ifs.sv
// stream interfaces for coordinate and kernel transactions
`timescale 1ns / 1ps
interface m52_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] first_coord;
    logic signed [15:0] second_coord;
    logic               last_dim;

    modport source (output valid, first_coord, second_coord, last_dim, input ready);
    modport sink (input valid, first_coord, second_coord, last_dim, output ready);
endinterface

interface m52_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] kernel_value;
    logic        dist_saturated;

    modport source (output valid, kernel_value, dist_saturated, input ready);
    modport sink (input valid, kernel_value, dist_saturated, output ready);
endinterface

>>> rtl/m52_front.sv
// front end: squared distance accumulation and pair closing
`timescale 1ns / 1ps
module m52_front
    import m52_pkg::*;
#(
    parameter int MAX_DIMS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [15:0]   first_coord,
    input  logic [15:0]   second_coord,
    input  logic          last_dim,
    output logic          push,
    output m52_item_t     push_item
);

    localparam int CW = $clog2(MAX_DIMS + 1);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             sat_reg, sat_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    logic signed [16:0] diff;
    logic [33:0]        sq_full;
    logic [ACC_W:0]     sum;
    logic [ACC_W-1:0]   sum_sat;
    logic               sat_now;
    logic [CW-1:0]      cnt_inc;
    logic               close;

    // squared difference and saturating sum
    always_comb
    begin
        diff    = 17'($signed(first_coord)) - 17'($signed(second_coord));
        sq_full = 34'($signed(diff) * $signed(diff));
        sum     = {1'b0, acc_reg} + {7'd0, sq_full[31:0]};
        sat_now = sat_reg | sum[ACC_W];
        sum_sat = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
        cnt_inc = cnt_reg + 1'b1;
        close   = last_dim | (cnt_inc >= CW'(MAX_DIMS));
    end

    // pair bookkeeping
    always_comb
    begin
        acc_next = acc_reg;
        sat_next = sat_reg;
        cnt_next = cnt_reg;
        push     = 1'b0;
        push_item.sq_dist = sum_sat;
        push_item.sat     = sat_now;
        if (take)
        begin
            if (close)
            begin
                push     = 1'b1;
                acc_next = '0;
                sat_next = 1'b0;
                cnt_next = '0;
            end
            else
            begin
                acc_next = sum_sat;
                sat_next = sat_now;
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            sat_reg <= sat_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/m52_queue.sv
// two-entry queue between front and back
`timescale 1ns / 1ps
module m52_queue
    import m52_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  m52_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output m52_item_t head
);

    m52_item_t  ent_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = ent_reg[rd_reg];

    // pointer and fill update
    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/m52_mul.sv
// 64x64 multiplier built from one 32x32 product per cycle
`timescale 1ns / 1ps
module m52_mul
    import m52_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [63:0]  x_reg, y_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_sh_reg;
    logic         pp_vld_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [31:0]  xp, yp;
    logic [127:0] pp_shifted;

    // select operand halves for this partial product
    always_comb
    begin
        xp = cnt_reg[1] ? x_reg[63:32] : x_reg[31:0];
        yp = cnt_reg[0] ? y_reg[63:32] : y_reg[31:0];
        pp_shifted = {64'd0, pp_reg} << {pp_sh_reg, 5'd0};
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= req.x;
            y_reg   <= req.y;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            pp_reg    <= 64'(xp * yp);
            pp_sh_reg <= 2'({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]});
            if (pp_vld_reg)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= 3'd0;
            pp_vld_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg   <= 1'b1;
                cnt_reg    <= 3'd0;
                pp_vld_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                pp_vld_reg <= (cnt_reg < 3'd4);
                cnt_reg    <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

>>> rtl/m52_div.sv
// restoring divider, 64-bit dividend by small divisor, one bit per cycle
`timescale 1ns / 1ps
module m52_div
    import m52_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [63:0] dvd_reg;
    logic [4:0]  dvs_reg;
    logic [4:0]  rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [5:0] rem_sh;
    logic       ge;
    logic [5:0] rem_sub;

    // one quotient bit
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[63]};
        ge      = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= 5'd0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[4:0] : rem_sh[4:0];
            dvd_reg <= {dvd_reg[62:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

>>> rtl/m52_back.sv
// back end: square root, exponential series and polynomial factor
`timescale 1ns / 1ps
module m52_back
    import m52_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  m52_item_t   q_head,
    output logic        q_pop,
    output mul_req_t    mul_req,
    input  mul_rsp_t    mul_rsp,
    output div_req_t    div_req,
    input  div_rsp_t    div_rsp,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [16:0] res_kval,
    output logic        res_sat
);

    localparam logic [63:0] ROUND = 64'd1 << (31 - OUT_FRAC_BITS);
    localparam int          SH    = 32 - OUT_FRAC_BITS;
    localparam logic [16:0] CAP   = (OUT_FRAC_BITS >= 17) ? 17'h1FFFF
                                                          : 17'(1 << OUT_FRAC_BITS);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQRT = 4'd1;
    localparam logic [3:0] ST_AMUL = 4'd2;
    localparam logic [3:0] ST_ACHK = 4'd3;
    localparam logic [3:0] ST_TMUL = 4'd4;
    localparam logic [3:0] ST_TDIV = 4'd5;
    localparam logic [3:0] ST_ESQ  = 4'd6;
    localparam logic [3:0] ST_PDIV = 4'd7;
    localparam logic [3:0] ST_PMUL = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0]       st_reg, st_next;
    logic [ACC_W-1:0] s_reg, s_next;
    logic [63:0]      v_reg, v_next;
    logic [63:0]      rt_reg, rt_next;
    logic [63:0]      bit_reg, bit_next;
    logic [63:0]      a_reg, a_next;
    logic [63:0]      t_reg, t_next;
    logic [63:0]      e_reg, e_next;
    logic [4:0]       n_reg, n_next;
    logic [2:0]       sq_reg, sq_next;
    logic [16:0]      kv_reg, kv_next;
    logic             ov_reg, ov_next;
    logic [16:0]      ok_reg, ok_next;
    logic             os_reg, os_next;

    logic [63:0] trial;
    logic [63:0] prod62;
    logic [63:0] quot3;
    logic [63:0] e_upd;
    logic [40:0] s5;
    logic [63:0] f_round;
    logic [63:0] f_out;

    // shared datapath terms
    always_comb
    begin
        trial   = rt_reg + bit_reg;
        prod62  = mul_rsp.prod[125:62];
        quot3   = mul_rsp.prod[126:63];
        e_upd   = n_reg[0] ? (e_reg - div_rsp.quotient) : (e_reg + div_rsp.quotient);
        s5      = {1'b0, s_reg, 2'b00} + {3'b000, s_reg};
        f_round = prod62 + ROUND;
        f_out   = f_round >> SH;
    end

    // evaluation sequencer
    always_comb
    begin
        st_next  = st_reg;
        s_next   = s_reg;
        v_next   = v_reg;
        rt_next  = rt_reg;
        bit_next = bit_reg;
        a_next   = a_reg;
        t_next   = t_reg;
        e_next   = e_reg;
        n_next   = n_reg;
        sq_next  = sq_reg;
        kv_next  = kv_reg;
        ov_next  = ov_reg;
        ok_next  = ok_reg;
        os_next  = os_reg;
        q_pop    = 1'b0;
        mul_req.start    = 1'b0;
        mul_req.x        = e_reg;
        mul_req.y        = t_reg;
        div_req.start    = 1'b0;
        div_req.dividend = prod62;
        div_req.divisor  = n_reg;

        // result register empties on a transaction
        if (ov_reg && res_ready)
        begin
            ov_next = 1'b0;
        end

        case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    s_next   = q_head.sq_dist;
                    v_next   = {10'd0, q_head.sq_dist, 16'd0};
                    rt_next  = 64'd0;
                    bit_next = ONE_Q62;
                    os_next  = q_head.sat;
                    if (q_head.sat)
                    begin
                        kv_next = 17'd0;
                        st_next = ST_DONE;
                    end
                    else
                    begin
                        st_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT:
            begin
                if (bit_reg == 64'd0)
                begin
                    mul_req.start = 1'b1;
                    mul_req.x     = rt_reg;
                    mul_req.y     = C5_Q32;
                    st_next       = ST_AMUL;
                end
                else
                begin
                    if (v_reg >= trial)
                    begin
                        v_next  = v_reg - trial;
                        rt_next = (rt_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        rt_next = rt_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            ST_AMUL:
            begin
                if (mul_rsp.done)
                begin
                    a_next  = mul_rsp.prod[79:16];
                    st_next = ST_ACHK;
                end
            end
            ST_ACHK:
            begin
                if (a_reg >= LIM_A)
                begin
                    kv_next = 17'd0;
                    st_next = ST_DONE;
                end
                else
                begin
                    t_next        = a_reg << 25;
                    e_next        = ONE_Q62;
                    n_next        = 5'd1;
                    mul_req.start = 1'b1;
                    mul_req.x     = ONE_Q62;
                    mul_req.y     = a_reg << 25;
                    st_next       = ST_TMUL;
                end
            end
            ST_TMUL:
            begin
                if (mul_rsp.done)
                begin
                    div_req.start = 1'b1;
                    st_next       = ST_TDIV;
                end
            end
            ST_TDIV:
            begin
                if (div_rsp.done)
                begin
                    e_next        = e_upd;
                    mul_req.start = 1'b1;
                    if (n_reg == N_TERMS)
                    begin
                        sq_next   = 3'd0;
                        mul_req.x = e_upd;
                        mul_req.y = e_upd;
                        st_next   = ST_ESQ;
                    end
                    else
                    begin
                        n_next    = n_reg + 5'd1;
                        mul_req.x = div_rsp.quotient;
                        mul_req.y = t_reg;
                        st_next   = ST_TMUL;
                    end
                end
            end
            ST_ESQ:
            begin
                if (mul_rsp.done)
                begin
                    e_next        = prod62;
                    mul_req.start = 1'b1;
                    if (sq_reg == N_SQUARES_LAST)
                    begin
                        // 5*S/3 by reciprocal multiplication
                        mul_req.x = {7'd0, s5, 16'd0};
                        mul_req.y = RECIP3_Q63;
                        st_next   = ST_PDIV;
                    end
                    else
                    begin
                        sq_next   = sq_reg + 3'd1;
                        mul_req.x = prod62;
                        mul_req.y = prod62;
                    end
                end
            end
            ST_PDIV:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.x     = ONE_Q32 + a_reg + quot3;
                    mul_req.y     = e_reg;
                    st_next       = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                if (mul_rsp.done)
                begin
                    kv_next = (f_out > {47'd0, CAP}) ? CAP : f_out[16:0];
                    st_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || res_ready)
                begin
                    ov_next = 1'b1;
                    ok_next = kv_reg;
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s_reg   <= s_next;
        v_reg   <= v_next;
        rt_reg  <= rt_next;
        a_reg   <= a_next;
        t_reg   <= t_next;
        e_reg   <= e_next;
        n_reg   <= n_next;
        sq_reg  <= sq_next;
        kv_reg  <= kv_next;
        ok_reg  <= ok_next;
        os_reg  <= os_next;
        bit_reg <= bit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    // sat flag follows the item into the result register
    logic osat_reg;
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_DONE && (!ov_reg || res_ready))
        begin
            osat_reg <= os_reg;
        end
    end

    assign res_valid = ov_reg;
    assign res_kval  = ok_reg;
    assign res_sat   = osat_reg;

endmodule

>>> rtl/matern52_kernel_evaluator.sv
// top level of the matern 5/2 covariance kernel evaluator
//
//  channel   dir  handshake     payload
//  samples   in   valid/ready   first_coord, second_coord, last_dim
//  results   out  valid/ready   kernel_value, dist_saturated
//
// coordinates are taken one per cycle while the two-entry pair queue has room
// a closed pair runs through the back end as 32 square root steps,
// then 20 series terms of one multiply and one divide each,
// five squarings and the polynomial factor, all on one shared multiplier and divider
// a saturated pair skips evaluation and goes from idle straight to the done state
// reset is asynchronous, active low, and empties the queue and the result register
// a stalled result holds in its register; the back end goes on up to its done state
`timescale 1ns / 1ps
module matern52_kernel_evaluator
    import m52_pkg::*;
#(
    parameter int MAX_DIMS      = 16,
    parameter int OUT_FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    m52_in_if.sink     samples,
    m52_out_if.source  results
);

    logic      take;
    logic      push;
    m52_item_t push_item;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    m52_item_t q_head;
    mul_req_t  mul_req;
    mul_rsp_t  mul_rsp;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    assign samples.ready = ~q_full;
    assign take          = samples.valid & ~q_full;

    m52_front #(.MAX_DIMS(MAX_DIMS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .first_coord  (samples.first_coord),
        .second_coord (samples.second_coord),
        .last_dim     (samples.last_dim),
        .push         (push),
        .push_item    (push_item)
    );

    m52_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    m52_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    m52_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    m52_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .mul_req   (mul_req),
        .mul_rsp   (mul_rsp),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .res_valid (results.valid),
        .res_ready (results.ready),
        .res_kval  (results.kernel_value),
        .res_sat   (results.dist_saturated)
    );

    localparam logic [16:0] KV_CAP = (OUT_FRAC_BITS >= 17) ? 17'h1FFFF
                                                           : 17'(1 << OUT_FRAC_BITS);

    // a saturated distance always gives a zero kernel value
    a_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.dist_saturated |-> results.kernel_value == 17'd0)
        else $error("saturated pair with nonzero kernel value");

    // kernel value never exceeds one
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.kernel_value <= KV_CAP)
        else $error("kernel value above one");

    // the shared units never finish in the same cycle
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_rsp.done && div_rsp.done))
        else $error("multiplier and divider finished together");

    // a pop only happens from a non-empty queue
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty pair queue");

endmodule

>>> tb/matern52_kernel_evaluator_test.sv
// self-checking testbench of the matern 5/2 kernel evaluator
`timescale 1ns / 1ps
module matern52_kernel_evaluator_test;
    import m52_pkg::*;

    localparam int          PAIR_DIMS   = 16;
    localparam int          FRAC_BITS   = 16;
    localparam int          ITEM_TARGET = 1150;
    localparam int          DRAIN_WAIT  = 3000;
    localparam longint      CYCLE_LIMIT = 6000000;
    localparam logic [16:0] KV_ONE      = 17'd65536;
    localparam logic [16:0] KV_ZERO     = 17'd0;

    typedef struct {
        logic [16:0] kernel_value;
        logic        dist_saturated;
        logic        typed;
    } kernel_exp_t;

    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic               last;
        logic               typed;
        logic [16:0]        typed_kv;
    } coord_row_t;

    logic   clk;
    logic   rst_n;
    longint cycles;
    int     fails;
    bit     no_idle;

    m52_in_if  in_bus ();
    m52_out_if out_bus ();

    // side info that travels with each driven transaction
    logic        row_typed;
    logic [16:0] row_typed_kv;

    matern52_kernel_evaluator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (in_bus),
        .results (out_bus)
    );

    // shadow state of the pair being accumulated
    logic [63:0] pair_sq_dist;
    logic        pair_sat;
    int          pair_dims;
    kernel_exp_t kernel_q[$];

    // floor((x*y) / 2^sh) kept to 64 bits
    function automatic logic [63:0] fixmul_shr(logic [63:0] x, logic [63:0] y, int sh);
        logic [127:0] prod;
        prod = {64'd0, x} * {64'd0, y};
        return 64'(prod >> sh);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // covariance of one squared distance, Q1.16
    function automatic logic [16:0] matern_value(logic [63:0] s);
        logic [63:0] r, a, t, e, term, p, f, kv, cap;
        r = int_sqrt(s << 16);
        a = (r * C5_Q32) >> 16;
        if (a >= LIM_A) return 17'd0;
        t    = a << 25;
        e    = ONE_Q62;
        term = ONE_Q62;
        for (int n = 1; n <= 20; n++)
        begin
            term = fixmul_shr(term, t, 62) / n;
            if (n % 2 == 1) e = e - term;
            else e = e + term;
        end
        for (int n = 0; n < 5; n++) e = fixmul_shr(e, e, 62);
        p   = ONE_Q32 + a + ((64'd5 * s) << 16) / 64'd3;
        f   = fixmul_shr(p, e, 62);
        kv  = (f + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
        cap = 64'd1 << FRAC_BITS;
        if (cap > 64'h1FFFF) cap = 64'h1FFFF;
        if (kv > cap) kv = cap;
        return kv[16:0];
    endfunction

    // clock and cycle watchdog
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // accepted input transaction: accumulate and predict
    always @(posedge clk)
    begin
        if (rst_n && in_bus.valid && in_bus.ready)
        begin
            automatic int          d;
            automatic logic [63:0] sum;
            automatic kernel_exp_t x;
            d   = int'(in_bus.first_coord) - int'(in_bus.second_coord);
            sum = pair_sq_dist + 64'(longint'(d) * longint'(d));
            if (sum > 64'(ACC_MAX))
            begin
                sum      = 64'(ACC_MAX);
                pair_sat = 1'b1;
            end
            pair_sq_dist = sum;
            pair_dims    = pair_dims + 1;
            if (in_bus.last_dim || pair_dims >= PAIR_DIMS)
            begin
                x.dist_saturated = pair_sat;
                x.kernel_value   = pair_sat ? 17'd0 : matern_value(pair_sq_dist);
                x.typed          = row_typed;
                if (row_typed) x.kernel_value = row_typed_kv;
                kernel_q.push_back(x);
                pair_sq_dist = 0;
                pair_sat     = 1'b0;
                pair_dims    = 0;
            end
        end
    end

    // accepted result transaction: compare with oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (kernel_q.size() == 0)
            begin
                $error("result with no expectation: kernel_value %0d", out_bus.kernel_value);
                fails++;
            end
            else
            begin
                automatic kernel_exp_t x = kernel_q.pop_front();
                if (out_bus.kernel_value !== x.kernel_value)
                begin
                    $error("kernel_value expected %0d actual %0d",
                           x.kernel_value, out_bus.kernel_value);
                    fails++;
                end
                if (out_bus.dist_saturated !== x.dist_saturated)
                begin
                    $error("dist_saturated expected %0d actual %0d",
                           x.dist_saturated, out_bus.dist_saturated);
                    fails++;
                end
            end
        end
    end

    // result side back-pressure
    initial
    begin
        automatic int stall;
        out_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge clk); while (!out_bus.valid);
        end
    end

    task automatic send_coord(logic signed [15:0] a, logic signed [15:0] b, logic last,
                              logic typed, logic [16:0] typed_kv);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid        <= 1'b1;
        in_bus.first_coord  <= a;
        in_bus.second_coord <= b;
        in_bus.last_dim     <= last;
        row_typed           <= typed;
        row_typed_kv        <= typed_kv;
        do @(posedge clk); while (!in_bus.ready);
    endtask

    task automatic wait_drained();
        while (kernel_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic signed [15:0] near_coord(logic signed [15:0] base);
        int v;
        v = int'(base) + $urandom_range(0, 2048) - 1024;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    // stimulus
    initial
    begin
        automatic coord_row_t        rows[$];
        automatic coord_row_t        row;
        automatic int                sent;
        automatic int                plen;
        automatic int                pairs;
        automatic bit                far_pair;
        automatic logic signed [15:0] a;
        automatic logic signed [15:0] b;

        rst_n               = 1'b0;
        cycles              = 0;
        fails               = 0;
        no_idle             = 1'b0;
        pair_sq_dist        = 0;
        pair_sat            = 1'b0;
        pair_dims           = 0;
        in_bus.valid        = 1'b0;
        in_bus.first_coord  = '0;
        in_bus.second_coord = '0;
        in_bus.last_dim     = 1'b0;
        row_typed           = 1'b0;
        row_typed_kv        = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: identical points, extremes, underflow, dimension cap
        rows.push_back('{16'sd0, 16'sd0, 1'b1, 1'b1, KV_ONE});
        rows.push_back('{16'sh7FFF, -16'sh8000, 1'b1, 1'b1, KV_ZERO});
        rows.push_back('{-16'sh8000, 16'sh7FFF, 1'b1, 1'b1, KV_ZERO});
        rows.push_back('{-16'sh8000, -16'sh8000, 1'b1, 1'b1, KV_ONE});
        rows.push_back('{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, KV_ONE});
        rows.push_back('{16'sd256, 16'sd0, 1'b1, 1'b0, KV_ZERO});
        rows.push_back('{16'sd0, 16'sd1, 1'b1, 1'b0, KV_ZERO});
        // a pair with no closing flag is closed by the dimension cap
        for (int i = 0; i < PAIR_DIMS; i++)
            rows.push_back('{16'(i * 37), 16'(-i * 11), 1'b0, 1'b0, KV_ZERO});
        foreach (rows[i])
            send_coord(rows[i].a, rows[i].b, rows[i].last, rows[i].typed, rows[i].typed_kv);
        sent  = rows.size();
        pairs = 0;

        // random pairs: mostly short and close together, some far or at full width
        while (sent < ITEM_TARGET)
        begin
            no_idle  = (pairs % 12) >= 9;
            far_pair = ($urandom_range(0, 9) == 0);
            plen     = ($urandom_range(0, 7) == 0) ? $urandom_range(1, PAIR_DIMS + 2)
                                                   : $urandom_range(1, 4);
            for (int i = 0; i < plen; i++)
            begin
                a = 16'($urandom);
                b = far_pair ? 16'($urandom) : near_coord(a);
                send_coord(a, b, (i == plen - 1), 1'b0, KV_ZERO);
                sent++;
            end
            pairs++;
            // hold off once until the back end has emptied
            if (pairs == 40)
            begin
                in_bus.valid <= 1'b0;
                wait_drained();
            end
        end
        in_bus.valid <= 1'b0;
        wait_drained();

        if (fails == 0 && kernel_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
